[sv/hpq_pkg.sv]
// Shared types, codes and constants for the binary max-heap priority queue.
package hpq_pkg;

    // Default number of heap slots.
    localparam int HEAP_DEPTH_DEFAULT = 32;

    // Field widths of the transaction payloads.
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 6;

    // Operation codes.
    localparam logic OP_INSERT  = 1'b0;
    localparam logic OP_EXTRACT = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    // Input transaction payload.
    typedef struct packed {
        logic                      op;
        logic signed [VALUE_W-1:0] value_in;
    } in_item_t;

    // Result transaction payload.
    typedef struct packed {
        logic signed [VALUE_W-1:0] value_out;
        logic [STATUS_W-1:0]       status;
        logic [OCC_W-1:0]          occupancy;
    } out_item_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UP_CMP,
        ST_UP_FIN,
        ST_EX_LOAD,
        ST_DN_LEFT,
        ST_DN_RIGHT,
        ST_DN_FIN,
        ST_DONE
    } seq_state_t;

endpackage

[sv/hpq_mem.sv]
// Heap storage: one write port and two read ports with registered read data.
module hpq_mem #(
    parameter int DEPTH  = hpq_pkg::HEAP_DEPTH_DEFAULT,
    parameter int ADDR_W = $clog2(hpq_pkg::HEAP_DEPTH_DEFAULT)
) (
    input  logic                              aclk,
    input  logic                              we,
    input  logic [ADDR_W-1:0]                 waddr,
    input  logic signed [hpq_pkg::VALUE_W-1:0] wdata,
    input  logic                              re0,
    input  logic [ADDR_W-1:0]                 raddr0,
    output logic signed [hpq_pkg::VALUE_W-1:0] rdata0,
    input  logic                              re1,
    input  logic [ADDR_W-1:0]                 raddr1,
    output logic signed [hpq_pkg::VALUE_W-1:0] rdata1
);

    logic signed [hpq_pkg::VALUE_W-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read ports; data holds until the next read on that port.
    always_ff @(posedge aclk) begin
        if (re0) begin
            rdata0 <= mem[raddr0];
        end
        if (re1) begin
            rdata1 <= mem[raddr1];
        end
    end

endmodule

[sv/hpq_seq.sv]
// Sequencer for sift-up and sift-down around one shared signed comparator.
module hpq_seq #(
    parameter int HEAP_DEPTH = hpq_pkg::HEAP_DEPTH_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  hpq_pkg::in_item_t  s_data,
    input  logic               out_free,
    output logic               res_valid,
    output hpq_pkg::out_item_t res
);

    localparam int ADDR_W = $clog2(HEAP_DEPTH);
    localparam int CNT_W  = $clog2(HEAP_DEPTH + 1);
    localparam int IDX_W  = ADDR_W + 1;
    localparam int VW     = hpq_pkg::VALUE_W;

    // Parent slot of a nonzero slot.
    function automatic logic [ADDR_W-1:0] parent_of(input logic [ADDR_W-1:0] p);
        parent_of = (p - ADDR_W'(1)) >> 1;
    endfunction

    // Left and right child slots, one bit wider than a slot address.
    function automatic logic [IDX_W-1:0] left_of(input logic [ADDR_W-1:0] p);
        left_of = {p, 1'b1};
    endfunction

    function automatic logic [IDX_W-1:0] right_of(input logic [ADDR_W-1:0] p);
        right_of = {p, 1'b1} + IDX_W'(1);
    endfunction

    hpq_pkg::seq_state_t state_reg, state_next;

    logic [CNT_W-1:0]            count_reg, count_next;
    logic [ADDR_W-1:0]           pos_reg, pos_next;
    logic signed [VW-1:0]        val_reg, val_next;
    logic                        best_left_reg, best_left_next;
    logic signed [VW-1:0]        best_val_reg, best_val_next;
    logic signed [VW-1:0]        res_val_reg, res_val_next;
    logic [hpq_pkg::STATUS_W-1:0] res_status_reg, res_status_next;

    // Memory port signals.
    logic                 mem_we, mem_re0, mem_re1;
    logic [ADDR_W-1:0]    mem_waddr, mem_raddr0, mem_raddr1;
    logic signed [VW-1:0] mem_wdata, mem_rdata0, mem_rdata1;

    // Shared comparator.
    logic signed [VW-1:0] cmp_a, cmp_b;
    logic                 cmp_gt;

    // Helper terms.
    logic                 accept;
    logic                 is_full, is_empty;
    logic [ADDR_W-1:0]    cnt_addr, par_cur, par_up;
    logic [IDX_W-1:0]     cnt_ext, dn_right;
    logic                 ins_at_root, up_root, ex_has_left;
    logic                 take_right, dn_move, dn_has_left;
    logic [ADDR_W-1:0]    dn_idx;
    logic [IDX_W-1:0]     root_left, root_right;
    logic [IDX_W-1:0]     dn_left, dn_next_left, dn_next_right;

    hpq_mem #(
        .DEPTH  (HEAP_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .aclk   (aclk),
        .we     (mem_we),
        .waddr  (mem_waddr),
        .wdata  (mem_wdata),
        .re0    (mem_re0),
        .raddr0 (mem_raddr0),
        .rdata0 (mem_rdata0),
        .re1    (mem_re1),
        .raddr1 (mem_raddr1),
        .rdata1 (mem_rdata1)
    );

    // Compare unit and the terms that steer the sequence.
    assign cmp_gt        = cmp_a > cmp_b;
    assign accept        = s_valid && (state_reg == hpq_pkg::ST_IDLE);
    assign is_full       = (count_reg == CNT_W'(HEAP_DEPTH));
    assign is_empty      = (count_reg == '0);
    assign cnt_addr      = count_reg[ADDR_W-1:0];
    assign cnt_ext       = IDX_W'(count_reg);
    assign ins_at_root   = (cnt_addr == '0);
    assign par_cur       = parent_of(pos_reg);
    assign par_up        = parent_of(par_cur);
    assign up_root       = (par_cur == '0);
    assign ex_has_left   = (IDX_W'(1) < cnt_ext);
    assign root_left     = left_of('0);
    assign root_right    = right_of('0);
    assign dn_left       = left_of(pos_reg);
    assign dn_right      = right_of(pos_reg);
    assign take_right    = (dn_right < cnt_ext) && cmp_gt;
    assign dn_move       = take_right || best_left_reg;
    assign dn_idx        = take_right ? dn_right[ADDR_W-1:0] : dn_left[ADDR_W-1:0];
    assign dn_next_left  = left_of(dn_idx);
    assign dn_next_right = right_of(dn_idx);
    assign dn_has_left   = (dn_next_left < cnt_ext);

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            hpq_pkg::ST_IDLE: begin
                if (s_valid) begin
                    case (s_data.op)
                        hpq_pkg::OP_INSERT: begin
                            if (is_full || ins_at_root) begin
                                state_next = hpq_pkg::ST_DONE;
                            end else begin
                                state_next = hpq_pkg::ST_UP_CMP;
                            end
                        end
                        hpq_pkg::OP_EXTRACT: begin
                            if (is_empty) begin
                                state_next = hpq_pkg::ST_DONE;
                            end else begin
                                state_next = hpq_pkg::ST_EX_LOAD;
                            end
                        end
                        default: state_next = hpq_pkg::ST_IDLE;
                    endcase
                end
            end
            hpq_pkg::ST_UP_CMP: begin
                if (!cmp_gt) begin
                    state_next = hpq_pkg::ST_DONE;
                end else if (up_root) begin
                    state_next = hpq_pkg::ST_UP_FIN;
                end
            end
            hpq_pkg::ST_UP_FIN: state_next = hpq_pkg::ST_DONE;
            hpq_pkg::ST_EX_LOAD: begin
                if (is_empty || !ex_has_left) begin
                    state_next = hpq_pkg::ST_DONE;
                end else begin
                    state_next = hpq_pkg::ST_DN_LEFT;
                end
            end
            hpq_pkg::ST_DN_LEFT: state_next = hpq_pkg::ST_DN_RIGHT;
            hpq_pkg::ST_DN_RIGHT: begin
                if (!dn_move) begin
                    state_next = hpq_pkg::ST_DONE;
                end else if (dn_has_left) begin
                    state_next = hpq_pkg::ST_DN_LEFT;
                end else begin
                    state_next = hpq_pkg::ST_DN_FIN;
                end
            end
            hpq_pkg::ST_DN_FIN: state_next = hpq_pkg::ST_DONE;
            hpq_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = hpq_pkg::ST_IDLE;
                end
            end
            default: state_next = hpq_pkg::ST_IDLE;
        endcase
    end

    // Memory controls, comparator operands and handshake outputs.
    always_comb begin
        s_ready    = 1'b0;
        res_valid  = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = pos_reg;
        mem_wdata  = val_reg;
        mem_re0    = 1'b0;
        mem_raddr0 = par_up;
        mem_re1    = 1'b0;
        mem_raddr1 = '0;
        cmp_a      = val_reg;
        cmp_b      = mem_rdata0;
        case (state_reg)
            hpq_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (accept) begin
                    case (s_data.op)
                        hpq_pkg::OP_INSERT: begin
                            if (!is_full && ins_at_root) begin
                                mem_we    = 1'b1;
                                mem_waddr = '0;
                                mem_wdata = s_data.value_in;
                            end else if (!is_full) begin
                                mem_re0    = 1'b1;
                                mem_raddr0 = parent_of(cnt_addr);
                            end
                        end
                        hpq_pkg::OP_EXTRACT: begin
                            if (!is_empty) begin
                                mem_re0    = 1'b1;
                                mem_raddr0 = '0;
                                mem_re1    = 1'b1;
                                mem_raddr1 = cnt_addr - ADDR_W'(1);
                            end
                        end
                        default: mem_re0 = 1'b0;
                    endcase
                end
            end
            hpq_pkg::ST_UP_CMP: begin
                // The new value climbs while it beats its parent.
                cmp_a  = val_reg;
                cmp_b  = mem_rdata0;
                mem_we = 1'b1;
                if (cmp_gt) begin
                    mem_wdata = mem_rdata0;
                    if (!up_root) begin
                        mem_re0    = 1'b1;
                        mem_raddr0 = par_up;
                    end
                end
            end
            hpq_pkg::ST_UP_FIN: begin
                mem_we = 1'b1;
            end
            hpq_pkg::ST_EX_LOAD: begin
                // The last entry moves to the root.
                if (!is_empty && !ex_has_left) begin
                    mem_we    = 1'b1;
                    mem_waddr = '0;
                    mem_wdata = mem_rdata1;
                end else if (!is_empty) begin
                    mem_re0    = 1'b1;
                    mem_raddr0 = root_left[ADDR_W-1:0];
                    mem_re1    = 1'b1;
                    mem_raddr1 = root_right[ADDR_W-1:0];
                end
            end
            hpq_pkg::ST_DN_LEFT: begin
                cmp_a = mem_rdata0;
                cmp_b = val_reg;
            end
            hpq_pkg::ST_DN_RIGHT: begin
                // Swap with the larger child, or settle here.
                cmp_a  = mem_rdata1;
                cmp_b  = best_val_reg;
                mem_we = 1'b1;
                if (dn_move) begin
                    mem_wdata = take_right ? mem_rdata1 : best_val_reg;
                    if (dn_has_left) begin
                        mem_re0    = 1'b1;
                        mem_raddr0 = dn_next_left[ADDR_W-1:0];
                        mem_re1    = 1'b1;
                        mem_raddr1 = dn_next_right[ADDR_W-1:0];
                    end
                end
            end
            hpq_pkg::ST_DN_FIN: begin
                mem_we = 1'b1;
            end
            hpq_pkg::ST_DONE: begin
                res_valid = out_free;
            end
            default: s_ready = 1'b0;
        endcase
    end

    // Datapath register updates.
    always_comb begin
        count_next      = count_reg;
        pos_next        = pos_reg;
        val_next        = val_reg;
        best_left_next  = best_left_reg;
        best_val_next   = best_val_reg;
        res_val_next    = res_val_reg;
        res_status_next = res_status_reg;
        case (state_reg)
            hpq_pkg::ST_IDLE: begin
                if (accept) begin
                    res_val_next    = '0;
                    res_status_next = hpq_pkg::STATUS_OK;
                    val_next        = s_data.value_in;
                    case (s_data.op)
                        hpq_pkg::OP_INSERT: begin
                            if (is_full) begin
                                res_status_next = hpq_pkg::STATUS_FULL;
                            end else begin
                                count_next = count_reg + CNT_W'(1);
                                pos_next   = cnt_addr;
                            end
                        end
                        hpq_pkg::OP_EXTRACT: begin
                            if (is_empty) begin
                                res_status_next = hpq_pkg::STATUS_EMPTY;
                            end else begin
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        default: count_next = count_reg;
                    endcase
                end
            end
            hpq_pkg::ST_UP_CMP: begin
                if (cmp_gt) begin
                    pos_next = par_cur;
                end
            end
            hpq_pkg::ST_EX_LOAD: begin
                res_val_next = mem_rdata0;
                val_next     = mem_rdata1;
                pos_next     = '0;
            end
            hpq_pkg::ST_DN_LEFT: begin
                best_left_next = cmp_gt;
                best_val_next  = cmp_gt ? mem_rdata0 : val_reg;
            end
            hpq_pkg::ST_DN_RIGHT: begin
                if (dn_move) begin
                    pos_next = dn_idx;
                end
            end
            default: pos_next = pos_reg;
        endcase
    end

    // Registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= hpq_pkg::ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
        pos_reg        <= pos_next;
        val_reg        <= val_next;
        best_left_reg  <= best_left_next;
        best_val_reg   <= best_val_next;
        res_val_reg    <= res_val_next;
        res_status_reg <= res_status_next;
    end

    // Result payload; occupancy wraps to the field width.
    assign res.value_out = res_val_reg;
    assign res.status    = res_status_reg;
    assign res.occupancy = hpq_pkg::OCC_W'(count_reg);

endmodule

[sv/max_heap_priority_queue.sv]
// Top level of the binary max-heap priority queue with its output register.
//
// A bounded max-heap of signed 32-bit values held in a two-read, one-write
// memory. Each input transaction is an insert or an extract-maximum and
// yields exactly one result transaction carrying the extracted value, a
// status and the occupancy. The block takes one transaction at a time. An
// insert into a full or an empty heap and an extract from an empty heap go
// straight to the done state; any other insert compares the value with its
// parent in ST_UP_CMP, level by level, until it no longer beats the parent
// or ST_UP_FIN writes it at the root. An extract loads the root and the last
// entry in ST_EX_LOAD; unless at most one entry is left, the moved entry then
// descends through ST_DN_LEFT and ST_DN_RIGHT at each level until it settles
// above its children or ST_DN_FIN writes it in a slot without children. Each
// level waits for a registered memory read, and the single comparator
// decides the left and right child in separate states. A finished result
// sits in the output register, and the next transaction is taken while it
// waits; if that register is still full when the next result is ready, the
// block holds in its done state until the result side drains it.
module max_heap_priority_queue #(
    parameter int HEAP_DEPTH = hpq_pkg::HEAP_DEPTH_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  hpq_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output hpq_pkg::out_item_t m_data
);

    logic               out_free;
    logic               res_valid;
    hpq_pkg::out_item_t res;
    logic               m_valid_reg, m_valid_next;
    hpq_pkg::out_item_t m_data_reg, m_data_next;

    hpq_seq #(
        .HEAP_DEPTH (HEAP_DEPTH)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res       (res)
    );

    // Output register: free when empty or being drained this cycle.
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (res_valid) begin
            m_valid_next = 1'b1;
            m_data_next  = res;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // One transaction at a time: the block is busy right after it accepts one.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while a transaction was still in progress");

    // A full report means the heap holds exactly its depth.
    a_full_occupancy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == hpq_pkg::STATUS_FULL)
            |-> (m_data.occupancy == hpq_pkg::OCC_W'(HEAP_DEPTH))
                && (m_data.value_out == '0))
        else $error("full status with wrong occupancy or value");

    // An empty report means nothing is stored.
    a_empty_occupancy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == hpq_pkg::STATUS_EMPTY)
            |-> (m_data.occupancy == '0) && (m_data.value_out == '0))
        else $error("empty status with nonzero occupancy or value");

endmodule
